// ===== rtl/lmdm_pkg.sv =====
// Shared types, constants and helpers for the lamp matrix duty monitor.
package lmdm_pkg;

    localparam int ROWS_DEF = 16;
    localparam int COLS_DEF = 16;
    localparam int CNT_W    = 32;
    localparam int CLK_W    = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_STROBE  = 2'd1;
    localparam logic [1:0] OP_DATA    = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] elapsed_cycles;
        logic [3:0]  strobe_row;
        logic [15:0] row_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  lamp_index;
        logic [31:0] duty_cycles;
        logic [31:0] period_cycles;
        logic        last_of_run;
    } t_out_item;

    // One counter store word: both counters of one lamp.
    typedef struct packed {
        logic [CNT_W-1:0] on_cnt;
        logic [CNT_W-1:0] off_cnt;
    } t_cnt_word;

    // Per-lamp update control from the sequencer.
    typedef struct packed {
        logic             emit;
        logic             lamp_on;
        logic [CNT_W-1:0] elapsed;
    } t_upd_ctl;

    function automatic logic [CNT_W-1:0] sat_add32(
        input logic [CNT_W-1:0] a,
        input logic [CNT_W-1:0] b
    );
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/lmdm_cnt_ram.sv =====
// Counter store: one word of on/off counters per lamp, registered read.
module lmdm_cnt_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  lmdm_pkg::t_cnt_word   i_wdata,
    output lmdm_pkg::t_cnt_word   o_rdata
);
    import lmdm_pkg::*;

    t_cnt_word        mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_cnt_word        r_rd_data;
    logic             r_rd_vld;

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/lmdm_lamp_upd.sv =====
// Per-lamp counter update: saturating accumulate, or latch and clear on emit.
module lmdm_lamp_upd (
    input  lmdm_pkg::t_cnt_word          i_cur,
    input  lmdm_pkg::t_upd_ctl           i_ctl,
    output lmdm_pkg::t_cnt_word          o_nxt,
    output logic [lmdm_pkg::CNT_W-1:0]   o_duty,
    output logic [lmdm_pkg::CNT_W-1:0]   o_period
);
    import lmdm_pkg::*;

    logic [CNT_W-1:0] on_sum;
    logic [CNT_W-1:0] off_sum;

    always_comb begin
        on_sum   = sat_add32(i_cur.on_cnt, i_ctl.elapsed);
        off_sum  = sat_add32(i_cur.off_cnt, i_ctl.elapsed);
        o_duty   = i_cur.on_cnt;
        // emit pass runs on an unselected row, so only the off side grows
        o_period = sat_add32(i_cur.on_cnt, off_sum);
        o_nxt    = i_cur;
        if (i_ctl.emit) begin
            o_nxt = '0;
        end else if (i_ctl.lamp_on) begin
            o_nxt.on_cnt = on_sum;
        end else begin
            o_nxt.off_cnt = off_sum;
        end
    end

endmodule

// ===== rtl/lamp_matrix_duty_monitor.sv =====
// Top level of the lamp matrix duty monitor: row sequencer, row state and output register.
//
// Lamp matrix duty monitor. Keeps a 64-bit cycle clock (advanced by advance
// items), a per-row time stamp and row data, and a pair of saturating 32-bit
// on/off counters per lamp held in one synchronous counter store. A data write
// brings the selected row up to date and then stores the new row bits. A
// strobe write naming a different, existing row brings the old row up to date,
// then walks the new row once more, adding its off time, emitting one item per
// lamp (duty = on count, period = on + off, saturating) and clearing that
// lamp's counters; the last item of the run carries last_of_run. Advance
// items update the clock in the idle state. A data write and a strobe change
// pass through a setup state and walk the row in the counter store, which
// reads one lamp and writes back one lamp per cycle in a two-stage
// read-modify-write, unless the output side stalls the emit pass. Items that
// change nothing (unused opcode, same row, row beyond the matrix) start no
// walk. The counter store is cleared at reset by per-lamp valid bits, so no
// clearing pass is needed. The per-lamp powered flag is never visible at the
// ports and is not kept.
module lamp_matrix_duty_monitor #(
    parameter int ROWS = lmdm_pkg::ROWS_DEF,
    parameter int COLS = lmdm_pkg::COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lmdm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lmdm_pkg::t_out_item o_out_item
);
    import lmdm_pkg::*;

    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLS);
    localparam int CNT_CW  = $clog2(COLS + 1);
    localparam int LAMPS   = ROWS * COLS;
    localparam int LAMP_AW = $clog2(LAMPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN
    } t_state;

    t_state            r_state;

    // architectural row state
    logic [CLK_W-1:0]  r_clock;
    logic [ROW_W-1:0]  r_sel_row;
    logic [COLS-1:0]   r_row_bits  [ROWS];
    logic [CLK_W-1:0]  r_row_stamp [ROWS];

    // job context
    logic              r_job_strobe;   // strobe change, else data write
    logic              r_emit;         // second pass of a strobe change
    logic [ROW_W-1:0]  r_pass_row;
    logic [ROW_W-1:0]  r_new_row;
    logic [COLS-1:0]   r_data;
    logic [COLS-1:0]   r_on_bits;
    logic [CNT_W-1:0]  r_elapsed;

    // two-stage walk over the row
    logic [CNT_CW-1:0] r_issue_cnt;
    logic              r_s1_vld;
    logic [COL_W-1:0]  r_s1_col;

    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              in_acc;
    logic              strobe_ok;
    logic              stall;
    logic              issue;
    logic              s1_fire;
    logic              pass_done;
    logic              last_col;
    logic [COL_W-1:0]  issue_col;
    logic [LAMP_AW-1:0] rd_addr;
    logic [LAMP_AW-1:0] wr_addr;
    logic [CLK_W-1:0]  stamp;
    logic [CLK_W-1:0]  diff;
    logic [CNT_W-1:0]  n_elapsed;

    t_cnt_word         rd_word;
    t_cnt_word         wr_word;
    t_upd_ctl          upd_ctl;
    logic [CNT_W-1:0]  duty;
    logic [CNT_W-1:0]  period;

    function automatic logic [LAMP_AW-1:0] f_lamp(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        return LAMP_AW'(int'(row) * COLS + int'(col));
    endfunction

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign strobe_ok = (i_in_item.opcode == OP_STROBE)
                    && (int'(i_in_item.strobe_row) < ROWS)
                    && (i_in_item.strobe_row[ROW_W-1:0] != r_sel_row);

    // only the emit pass waits on the output side
    assign stall     = r_emit && r_out_valid && !i_out_ready;
    assign issue     = (r_state == S_RUN) && !stall && (r_issue_cnt < CNT_CW'(COLS));
    assign issue_col = r_issue_cnt[COL_W-1:0];
    assign s1_fire   = (r_state == S_RUN) && r_s1_vld && !stall;
    assign last_col  = (r_s1_col == COL_W'(COLS - 1));
    assign pass_done = s1_fire && last_col;
    assign rd_addr   = f_lamp(r_pass_row, issue_col);
    assign wr_addr   = f_lamp(r_pass_row, r_s1_col);

    // elapsed span of the row being brought up to date; a stamp at or past
    // the clock (clock wrap) counts nothing
    always_comb begin
        stamp = r_row_stamp[r_pass_row];
        diff  = r_clock - stamp;
        if (stamp >= r_clock) begin
            n_elapsed = '0;
        end else if (|diff[CLK_W-1:CNT_W]) begin
            n_elapsed = CNT_MAX;
        end else begin
            n_elapsed = diff[CNT_W-1:0];
        end
    end

    assign upd_ctl.emit    = r_emit;
    assign upd_ctl.lamp_on = r_on_bits[r_s1_col];
    assign upd_ctl.elapsed = r_elapsed;

    lmdm_cnt_ram #(
        .DEPTH (LAMPS),
        .AW    (LAMP_AW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (issue),
        .i_raddr (rd_addr),
        .i_we    (s1_fire),
        .i_waddr (wr_addr),
        .i_wdata (wr_word),
        .o_rdata (rd_word)
    );

    lmdm_lamp_upd u_lamp_upd (
        .i_cur    (rd_word),
        .i_ctl    (upd_ctl),
        .o_nxt    (wr_word),
        .o_duty   (duty),
        .o_period (period)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_clock      <= '0;
            r_sel_row    <= '0;
            r_job_strobe <= 1'b0;
            r_emit       <= 1'b0;
            r_issue_cnt  <= '0;
            r_s1_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                r_row_bits[r]  <= '0;
                r_row_stamp[r] <= '0;
            end
        end else begin
            // output register: loaded by the emit pass, freed when taken
            if (s1_fire && r_emit) begin
                r_out_valid              <= 1'b1;
                r_out_item.lamp_index    <= 8'(wr_addr);
                r_out_item.duty_cycles   <= duty;
                r_out_item.period_cycles <= period;
                r_out_item.last_of_run   <= last_col;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_item.opcode)
                            OP_ADVANCE: begin
                                r_clock <= r_clock + CLK_W'(i_in_item.elapsed_cycles);
                            end
                            OP_DATA: begin
                                r_pass_row   <= r_sel_row;
                                r_emit       <= 1'b0;
                                r_job_strobe <= 1'b0;
                                r_data       <= i_in_item.row_data[COLS-1:0];
                                r_on_bits    <= r_row_bits[r_sel_row];
                                r_state      <= S_SETUP;
                            end
                            OP_STROBE: begin
                                if (strobe_ok) begin
                                    r_pass_row   <= r_sel_row;
                                    r_emit       <= 1'b0;
                                    r_job_strobe <= 1'b1;
                                    r_new_row    <= i_in_item.strobe_row[ROW_W-1:0];
                                    r_on_bits    <= r_row_bits[r_sel_row];
                                    r_state      <= S_SETUP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SETUP: begin
                    r_row_stamp[r_pass_row] <= r_clock;
                    r_elapsed               <= n_elapsed;
                    r_issue_cnt             <= '0;
                    r_s1_vld                <= 1'b0;
                    r_state                 <= S_RUN;
                end
                S_RUN: begin
                    if (!stall) begin
                        r_s1_vld <= issue;
                        if (issue) begin
                            r_s1_col    <= issue_col;
                            r_issue_cnt <= r_issue_cnt + CNT_CW'(1);
                        end
                    end
                    if (pass_done) begin
                        if (r_emit) begin
                            r_sel_row <= r_new_row;
                            r_emit    <= 1'b0;
                            r_state   <= S_IDLE;
                        end else if (r_job_strobe) begin
                            // new row is unselected: all lamps count as off
                            r_pass_row <= r_new_row;
                            r_emit     <= 1'b1;
                            r_on_bits  <= '0;
                            r_state    <= S_SETUP;
                        end else begin
                            r_row_bits[r_pass_row] <= r_data;
                            r_state                <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
